/* rtl/osr_pkg.sv */
`default_nettype none
package osr_pkg;

	localparam int COORD_W = 48;
	localparam int EXT_W = 47;
	localparam int LIMIT_W = 32;
	localparam int MODE_W = 2;
	localparam int VER_W = 8;
	localparam int NUM_W = COORD_W + 2;
	localparam int Q_W = COORD_W + 1;
	localparam int DIV_W = EXT_W + 1;
	localparam int SPAN_W = COORD_W + 1;
	localparam int MERGE_STAGES = 4;
	localparam int OSR_LAT = Q_W + 1 + MERGE_STAGES;
	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	localparam logic [VER_W-1:0] EXPECTED_VERSION = 8'd1;
	localparam logic [EXT_W-1:0] EXTENT_RST = 47'd67108864;

	typedef enum logic [1:0] {
		ST_INVALID = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FINITE = 2'd2,
		ST_OVER = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_EXTENT = 2'd0,
		REG_HYST = 2'd1,
		REG_MODE = 2'd2,
		REG_VERSION = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic vld;
		status_t status;
		logic [LIMIT_W-1:0] limit;
	} side_t;

endpackage
`default_nettype wire

/* rtl/osr_lane.sv */
`default_nettype none
module osr_lane (
	input wire logic clk,
	input wire logic signed [osr_pkg::COORD_W-1:0] coord,
	input wire logic [osr_pkg::EXT_W-1:0] extent,
	output logic signed [osr_pkg::COORD_W-1:0] sector
);
	import osr_pkg::*;

	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] mag;
	logic [DIV_W-1:0] dvs;
	logic [DIV_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0] qd_s [0:Q_W];
	logic neg_s [0:Q_W];

	// Sector is floor((2w + e) / 2e); a negative numerator n is folded as ~n.
	assign num = {coord[COORD_W-1], coord, 1'b0} + {{(NUM_W-EXT_W){1'b0}}, extent};
	assign mag = num[NUM_W-1] ? ~num : num;
	assign dvs = {extent, 1'b0};

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		qd_s[0] <= mag[Q_W-1:0];
		neg_s[0] <= num[NUM_W-1];
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DIV_W:0] trial;
		logic [DIV_W:0] diff;
		logic ge;
		assign trial = {rem_s[k], qd_s[k][Q_W-1]};
		assign diff = trial - {1'b0, dvs};
		assign ge = trial >= {1'b0, dvs};
		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			qd_s[k+1] <= {qd_s[k][Q_W-2:0], ge};
			neg_s[k+1] <= neg_s[k];
		end
	end

	assign sector = neg_s[Q_W] ? ~qd_s[Q_W][COORD_W-1:0] : qd_s[Q_W][COORD_W-1:0];

endmodule
`default_nettype wire

/* rtl/osr_merge.sv */
`default_nettype none
module osr_merge (
	input wire logic clk,
	input wire logic arst_n,
	input wire osr_pkg::side_t side,
	input wire logic signed [osr_pkg::COORD_W-1:0] first_in [0:2],
	input wire logic signed [osr_pkg::COORD_W-1:0] last_in [0:2],
	output logic done,
	output logic [1:0] range_status,
	output logic signed [osr_pkg::COORD_W-1:0] first_out [0:2],
	output logic signed [osr_pkg::COORD_W-1:0] last_out [0:2],
	output logic [osr_pkg::LIMIT_W-1:0] sector_count
);
	import osr_pkg::*;

	logic [SPAN_W-1:0] span [0:2];
	logic big [0:2];
	logic vld_s1, vld_s2, vld_s3;
	side_t side_s1, side_s2, side_s3;
	logic signed [COORD_W-1:0] first_s1 [0:2], first_s2 [0:2], first_s3 [0:2];
	logic signed [COORD_W-1:0] last_s1 [0:2], last_s2 [0:2], last_s3 [0:2];
	logic [LIMIT_W-1:0] spx_s1, spy_s1, spz_s1, spz_s2;
	logic over_s1, over_s2, over_s3;
	logic [2*LIMIT_W-1:0] prod_s2, prod_s3;
	logic over_now;

	for (genvar a = 0; a < 3; a++) begin : g_span
		assign span[a] = {last_in[a][COORD_W-1], last_in[a]}
			- {first_in[a][COORD_W-1], first_in[a]} + SPAN_W'(1);
		// A span above the limit is oversized whatever the other axes give.
		assign big[a] = span[a] > {{(SPAN_W-LIMIT_W){1'b0}}, side.limit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= side.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done <= vld_s3;
		end
	end

	assign over_now = over_s3 || (prod_s3 > {{LIMIT_W{1'b0}}, side_s3.limit});

	always_ff @(posedge clk) begin
		side_s1 <= side;
		first_s1 <= first_in;
		last_s1 <= last_in;
		spx_s1 <= span[0][LIMIT_W-1:0];
		spy_s1 <= span[1][LIMIT_W-1:0];
		spz_s1 <= span[2][LIMIT_W-1:0];
		over_s1 <= big[0] || big[1] || big[2];

		side_s2 <= side_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		spz_s2 <= spz_s1;
		prod_s2 <= spx_s1 * spy_s1;
		over_s2 <= over_s1;

		side_s3 <= side_s2;
		first_s3 <= first_s2;
		last_s3 <= last_s2;
		prod_s3 <= prod_s2[LIMIT_W-1:0] * spz_s2;
		over_s3 <= over_s2 || (prod_s2 > {{LIMIT_W{1'b0}}, side_s2.limit});

		if (side_s3.status != ST_FINITE) begin
			range_status <= side_s3.status;
			sector_count <= '0;
			for (int a = 0; a < 3; a++) begin
				first_out[a] <= '0;
				last_out[a] <= '0;
			end
		end else begin
			range_status <= over_now ? ST_OVER : ST_FINITE;
			sector_count <= over_now ? '0 : prod_s3[LIMIT_W-1:0];
			first_out <= first_s3;
			last_out <= last_s3;
		end
	end

endmodule
`default_nettype wire

/* rtl/overlapping_sector_range.sv */
// Channel | Signals                                   | Handshake
// input   | lo_x..hi_z, enumeration_limit            | start && !busy
// result  | range_status, first/last_sector_*, count | done, one cycle
// config  | APB, 64-bit data, register i at 8*i      | psel&penable&pwrite
// A new box is taken every cycle; busy is held low.
// A result reaches the ports, with done, through an input register and the
// 49-stage restoring divider in each of the six corner lanes, then three merge
// stages and the output register.
// Reset clears the valid pipeline and restores register defaults.
// The receiver cannot stall, so results never wait.
`default_nettype none
module overlapping_sector_range (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [osr_pkg::COORD_W-1:0] lo_x,
	input wire logic signed [osr_pkg::COORD_W-1:0] lo_y,
	input wire logic signed [osr_pkg::COORD_W-1:0] lo_z,
	input wire logic signed [osr_pkg::COORD_W-1:0] hi_x,
	input wire logic signed [osr_pkg::COORD_W-1:0] hi_y,
	input wire logic signed [osr_pkg::COORD_W-1:0] hi_z,
	input wire logic [osr_pkg::LIMIT_W-1:0] enumeration_limit,
	output logic done,
	output logic [1:0] range_status,
	output logic signed [osr_pkg::COORD_W-1:0] first_sector_x,
	output logic signed [osr_pkg::COORD_W-1:0] first_sector_y,
	output logic signed [osr_pkg::COORD_W-1:0] first_sector_z,
	output logic signed [osr_pkg::COORD_W-1:0] last_sector_x,
	output logic signed [osr_pkg::COORD_W-1:0] last_sector_y,
	output logic signed [osr_pkg::COORD_W-1:0] last_sector_z,
	output logic [osr_pkg::LIMIT_W-1:0] sector_count,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [osr_pkg::APB_AW-1:0] paddr,
	input wire logic [osr_pkg::APB_DW-1:0] pwdata,
	output logic [osr_pkg::APB_DW-1:0] prdata,
	output logic pready
);
	import osr_pkg::*;

	logic [EXT_W-1:0] extent_q;
	logic [EXT_W-1:0] hyst_q;
	logic [MODE_W-1:0] mode_q;
	logic [VER_W-1:0] version_q;
	reg_idx_t widx;
	logic wr_en;
	logic policy_ok, is_empty;
	side_t side_in;
	side_t side_s [0:Q_W];
	logic signed [COORD_W-1:0] lo_c [0:2];
	logic signed [COORD_W-1:0] hi_c [0:2];
	logic signed [COORD_W-1:0] first_l [0:2];
	logic signed [COORD_W-1:0] last_l [0:2];
	logic signed [COORD_W-1:0] first_o [0:2];
	logic signed [COORD_W-1:0] last_o [0:2];

	assign busy = 1'b0;
	assign pready = 1'b1;
	assign widx = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_q <= EXTENT_RST;
			hyst_q <= '0;
			mode_q <= '0;
			version_q <= EXPECTED_VERSION;
		end else if (wr_en) begin
			case (widx)
				REG_EXTENT: extent_q <= pwdata[EXT_W-1:0];
				REG_HYST: hyst_q <= pwdata[EXT_W-1:0];
				REG_MODE: mode_q <= pwdata[MODE_W-1:0];
				REG_VERSION: version_q <= pwdata[VER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_EXTENT: prdata = {{(APB_DW-EXT_W){1'b0}}, extent_q};
			REG_HYST: prdata = {{(APB_DW-EXT_W){1'b0}}, hyst_q};
			REG_MODE: prdata = {{(APB_DW-MODE_W){1'b0}}, mode_q};
			REG_VERSION: prdata = {{(APB_DW-VER_W){1'b0}}, version_q};
			default: prdata = '0;
		endcase
	end

	assign policy_ok = (version_q == EXPECTED_VERSION) && (extent_q != '0)
		&& ({hyst_q, 1'b0} < {1'b0, extent_q}) && (mode_q <= MODE_W'(1));

	assign lo_c[0] = lo_x;
	assign lo_c[1] = lo_y;
	assign lo_c[2] = lo_z;
	assign hi_c[0] = hi_x;
	assign hi_c[1] = hi_y;
	assign hi_c[2] = hi_z;
	assign is_empty = (hi_x <= lo_x) || (hi_y <= lo_y) || (hi_z <= lo_z);

	always_comb begin
		side_in.vld = start && !busy;
		side_in.limit = enumeration_limit;
		if (!policy_ok || enumeration_limit == '0) begin
			side_in.status = ST_INVALID;
		end else if (is_empty) begin
			side_in.status = ST_EMPTY;
		end else begin
			side_in.status = ST_FINITE;
		end
	end

	// Side information rides alongside the divider lanes, stage for stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) begin
				side_s[k] <= '0;
			end
		end else begin
			side_s[0] <= side_in;
			for (int k = 0; k < Q_W; k++) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_lane
		osr_lane u_first (
			.clk(clk),
			.coord(lo_c[a]),
			.extent(extent_q),
			.sector(first_l[a])
		);
		// The exclusive maximum is lowered by one LSB before mapping.
		osr_lane u_last (
			.clk(clk),
			.coord(hi_c[a] - COORD_W'(1)),
			.extent(extent_q),
			.sector(last_l[a])
		);
	end

	osr_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.side(side_s[Q_W]),
		.first_in(first_l),
		.last_in(last_l),
		.done(done),
		.range_status(range_status),
		.first_out(first_o),
		.last_out(last_o),
		.sector_count(sector_count)
	);

	assign first_sector_x = first_o[0];
	assign first_sector_y = first_o[1];
	assign first_sector_z = first_o[2];
	assign last_sector_x = last_o[0];
	assign last_sector_y = last_o[1];
	assign last_sector_z = last_o[2];

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##OSR_LAT done)
		else $error("accepted box produced no result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OSR_LAT))
		else $error("result without an accepted box");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_status != ST_FINITE) |-> (sector_count == '0))
		else $error("nonzero count on non-finite status");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (range_status == ST_INVALID || range_status == ST_EMPTY))
		|-> (first_sector_x == '0 && last_sector_z == '0))
		else $error("sector corners not cleared");

endmodule
`default_nettype wire
